// ===== rtl/scb_pkg.sv =====
// Shared types, codes and constants for the statistics counter bank.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

    localparam int NUM_COUNTERS = 64;
    localparam int IDX_W        = 6;    // width of counter_index / result_index
    localparam int CNT_W        = 7;    // width of active_counters, holds NUM_COUNTERS
    localparam int VAL_W        = 64;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERBOSE = 1'b1;

    typedef enum logic [2:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_SET   = 3'd2,
        OP_RAISE = 3'd3,
        OP_READ  = 3'd4,
        OP_DUMP  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [IDX_W-1:0]        counter_index;
        logic signed [VAL_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        result_index;
        logic signed [VAL_W-1:0] result_count;
        logic [1:0]              status;
        logic                    last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_ERR,
        S_DRD,
        S_DCHK,
        S_DFIN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_UPDATE,
        EM_ERROR,
        EM_PEND_MID,
        EM_PEND_LAST,
        EM_EMPTY
    } emit_t;

    typedef struct packed {
        logic  accept;       // latch item, read its counter
        logic  sweep_start;  // clear sweep pointer and pending slot
        logic  sweep_read;   // read counter at sweep pointer
        logic  sweep_step;   // advance pointer, capture qualifying counter
        emit_t emit;
    } scb_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic in_dump;
        logic in_reserved;
        logic in_oob;
        logic sweep_empty;
        logic sweep_hit;
        logic pend_valid;
        logic ptr_end;
    } scb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scb_ctrl.sv =====
// Sequencer for the counter bank: decodes items, runs the dump sweep.
// Depends on scb_pkg; drives scb_datapath through scb_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module scb_ctrl
    import scb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire scb_stat_t stat,
    output scb_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd.accept       = 1'b0;
        cmd.sweep_start  = 1'b0;
        cmd.sweep_read   = 1'b0;
        cmd.sweep_step   = 1'b0;
        cmd.emit         = EM_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_reserved)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.in_dump)
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next = stat.sweep_empty ? S_DFIN : S_DRD;
                    end
                    else if (stat.in_oob)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = EM_UPDATE;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = EM_ERROR;
                    state_next = S_IDLE;
                end
            end
            S_DRD:
            begin
                cmd.sweep_read = 1'b1;
                state_next     = S_DCHK;
            end
            S_DCHK:
            begin
                // hold while a new hit would overwrite a pending result still unsent
                if (!(stat.sweep_hit && stat.pend_valid && !stat.slot_free))
                begin
                    if (stat.sweep_hit && stat.pend_valid)
                    begin
                        cmd.emit = EM_PEND_MID;
                    end
                    cmd.sweep_step = 1'b1;
                    state_next = stat.ptr_end ? S_DFIN : S_DRD;
                end
            end
            S_DFIN:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = stat.pend_valid ? EM_PEND_LAST : EM_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/scb_datapath.sv =====
// Counter store, update arithmetic, dump pending slot and output register.
// Depends on scb_pkg; controlled by scb_ctrl through scb_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module scb_datapath
    import scb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_item_t              in_data,
    output out_item_t                  out_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire scb_cmd_t              cmd,
    output scb_stat_t                  stat
);

    // configuration
    logic [CNT_W-1:0] active_reg;
    logic             verbose_reg;
    logic [CNT_W-1:0] n_eff;

    // counter store with per-entry valid bits (invalid reads as zero)
    logic [VAL_W-1:0]        mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] vld_reg;
    logic [VAL_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] cur_val;

    // latched item
    opcode_t                 op_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] operand_reg;

    // sweep
    logic [CNT_W-1:0]        ptr_reg;
    logic                    pend_valid_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic signed [VAL_W-1:0] pend_cnt_reg;

    // update path
    logic signed [VAL_W-1:0] new_val;
    logic                    wr_en;

    // output
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;

    assign n_eff = (active_reg > CNT_W'(NUM_COUNTERS)) ? CNT_W'(NUM_COUNTERS) : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= CNT_W'(NUM_COUNTERS);
            verbose_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ACTIVE:  active_reg  <= cfg_wdata;
                CFG_VERBOSE: verbose_reg <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    assign rd_en   = cmd.accept || cmd.sweep_read;
    assign rd_addr = cmd.accept ? in_data.counter_index : ptr_reg[IDX_W-1:0];
    assign cur_val = rd_vld_reg ? $signed(rd_data_reg) : '0;

    always_comb
    begin
        case (op_reg)
            OP_INC:   new_val = cur_val + VAL_W'(1);
            OP_DEC:   new_val = cur_val - VAL_W'(1);
            OP_SET:   new_val = operand_reg;
            OP_RAISE: new_val = (cur_val < operand_reg) ? operand_reg : cur_val;
            default:  new_val = cur_val;
        endcase
    end

    assign wr_en = (cmd.emit == EM_UPDATE) && (op_reg != OP_READ);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= new_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= opcode_t'(in_data.opcode);
            idx_reg     <= in_data.counter_index;
            operand_reg <= in_data.operand_value;
        end
        if (cmd.sweep_step && stat.sweep_hit)
        begin
            pend_idx_reg <= ptr_reg[IDX_W-1:0];
            pend_cnt_reg <= cur_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.sweep_start)
        begin
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.sweep_step)
        begin
            ptr_reg <= ptr_reg + CNT_W'(1);
            if (stat.sweep_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        case (cmd.emit)
            EM_UPDATE:
            begin
                out_next.result_index = idx_reg;
                out_next.result_count = cur_val;
                out_next.status       = ST_OK;
                out_next.last_result  = 1'b1;
            end
            EM_ERROR:
            begin
                out_next.result_index = idx_reg;
                out_next.result_count = '0;
                out_next.status       = ST_RANGE;
                out_next.last_result  = 1'b1;
            end
            EM_PEND_MID, EM_PEND_LAST:
            begin
                out_next.result_index = pend_idx_reg;
                out_next.result_count = pend_cnt_reg;
                out_next.status       = ST_OK;
                out_next.last_result  = (cmd.emit == EM_PEND_LAST);
            end
            EM_EMPTY:
            begin
                out_next.result_index = '0;
                out_next.result_count = '0;
                out_next.status       = ST_EMPTY;
                out_next.last_result  = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != EM_NONE)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.slot_free   = !out_valid_reg || out_ready;
    assign stat.in_dump     = (in_data.opcode == OP_DUMP);
    assign stat.in_reserved = (in_data.opcode > OP_DUMP);
    assign stat.in_oob      = ({1'b0, in_data.counter_index} >= n_eff);
    assign stat.sweep_empty = (n_eff == '0);
    assign stat.sweep_hit   = (cur_val != '0) || verbose_reg;
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.ptr_end     = ((ptr_reg + CNT_W'(1)) == n_eff);

endmodule

`default_nettype wire

// ===== rtl/statistics_counter_bank.sv =====
// Top level of the statistics counter bank: controller plus datapath.
// Depends on scb_pkg, scb_ctrl and scb_datapath.
//
//   channel | signals                       | payload
//   --------+-------------------------------+----------------------------------
//   in      | in_valid / in_ready           | in_data  (in_item_t)
//   out     | out_valid / out_ready         | out_data (out_item_t)
//   cfg     | cfg_we, cfg_addr, cfg_wdata   | 0 active_counters, 1 dump_verbose
//
// Update and read items make one registered store read, then the update write
// and result load; out-of-range items load an error result. Dump runs a read
// and a check state per active counter on the single store read port.
// Reserved opcodes leave the sequencer idle. A stalled output holds the
// sequencer; the output register lets the next item be taken while the last
// result waits. Reset clears all counters at once through valid bits.
`timescale 1ns / 1ps
`default_nettype none

module statistics_counter_bank
    import scb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CNT_W-1:0]      cfg_wdata
);

    scb_cmd_t  cmd;
    scb_stat_t stat;

    scb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_reserved_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.opcode > OP_DUMP)) |=> in_ready)
        else $error("reserved opcode left the sequencer busy");

    a_item_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.opcode <= OP_DUMP)) |=> !in_ready)
        else $error("item accepted without entering a busy state");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |-> stat.slot_free)
        else $error("result loaded over an unsent result");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_EMPTY)) |-> out_data.last_result)
        else $error("empty dump result not marked last");

endmodule

`default_nettype wire

// ===== test/statistics_counter_bank_checker.sv =====
// Scoreboard for the statistics counter bank: mirrors the counters and registers,
// predicts the reports of every accepted item and compares them in order.
// Depends on scb_pkg only; watches the ports of the block and drives nothing into it.
`timescale 1ns / 1ps

module statistics_counter_bank_checker
    import scb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CNT_W-1:0]      cfg_wdata,
    output int                    mismatches,
    output int                    reports_outstanding,
    output int                    items_seen,
    output int                    dumps_seen,
    output int                    reports_seen
);

    localparam int PRINT_CAP = 40;

    logic signed [VAL_W-1:0] counter_mirror [NUM_COUNTERS];
    logic [CNT_W-1:0]        active_setting;
    logic                    verbose_setting;
    out_item_t               pending_reports [$];

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] counter bank mismatch: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic predict_counter_op(input in_item_t item);
        int                      live;
        int                      last_hit;
        logic signed [VAL_W-1:0] prior;
        logic [IDX_W-1:0]        idx;
        live = (active_setting > NUM_COUNTERS) ? NUM_COUNTERS : int'(active_setting);
        idx  = item.counter_index;
        items_seen++;
        if (item.opcode == OP_DUMP) begin
            dumps_seen++;
            last_hit = -1;
            for (int i = 0; i < live; i++)
                if (counter_mirror[i] != 0 || verbose_setting)
                    last_hit = i;
            if (last_hit < 0)
                pending_reports.push_back(out_item_t'{result_index: '0, result_count: '0,
                                                      status: ST_EMPTY, last_result: 1'b1});
            else
                for (int i = 0; i <= last_hit; i++)
                    if (counter_mirror[i] != 0 || verbose_setting)
                        pending_reports.push_back(out_item_t'{
                            result_index: IDX_W'(i), result_count: counter_mirror[i],
                            status: ST_OK, last_result: (i == last_hit)});
        end
        else if (item.opcode > OP_DUMP) begin
            // reserved opcodes: no effect, no report
        end
        else if (int'(idx) >= live) begin
            pending_reports.push_back(out_item_t'{result_index: idx, result_count: '0,
                                                  status: ST_RANGE, last_result: 1'b1});
        end
        else begin
            prior = counter_mirror[idx];
            case (item.opcode)
                OP_INC:   counter_mirror[idx] = prior + 64'sd1;
                OP_DEC:   counter_mirror[idx] = prior - 64'sd1;
                OP_SET:   counter_mirror[idx] = item.operand_value;
                OP_RAISE:
                    if ($signed(prior) < $signed(item.operand_value))
                        counter_mirror[idx] = item.operand_value;
                default: ;
            endcase
            pending_reports.push_back(out_item_t'{result_index: idx, result_count: prior,
                                                  status: ST_OK, last_result: 1'b1});
        end
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            report_mismatch("report with nothing expected, index",
                            VAL_W'(got.result_index), '0);
            return;
        end
        want = pending_reports.pop_front();
        if (got.result_index !== want.result_index)
            report_mismatch("result_index", VAL_W'(got.result_index),
                            VAL_W'(want.result_index));
        if (got.result_count !== want.result_count)
            report_mismatch("result_count", got.result_count, want.result_count);
        if (got.status !== want.status)
            report_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
        if (got.last_result !== want.last_result)
            report_mismatch("last_result", VAL_W'(got.last_result),
                            VAL_W'(want.last_result));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                counter_mirror[i] = '0;
            active_setting  = CNT_W'(NUM_COUNTERS);
            verbose_setting = 1'b0;
            pending_reports.delete();
            mismatches   = 0;
            items_seen   = 0;
            dumps_seen   = 0;
            reports_seen = 0;
            reports_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_addr)
                    CFG_ACTIVE:  active_setting  = cfg_wdata;
                    CFG_VERBOSE: verbose_setting = cfg_wdata[0];
                    default: ;
                endcase
            // compare first: a report leaving now belongs to an earlier item
            if (out_valid && out_ready)
                check_report(out_data);
            if (in_valid && in_ready)
                predict_counter_op(in_data);
            reports_outstanding <= pending_reports.size();
        end
    end

endmodule

// ===== test/statistics_counter_bank_test.sv =====
// Top of the statistics counter bank regression: clock, reset, stimulus and verdict.
// Depends on scb_pkg, the statistics_counter_bank RTL and statistics_counter_bank_checker.
`timescale 1ns / 1ps

module statistics_counter_bank_test;
    import scb_pkg::*;

    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 200;

    localparam logic [2:0] OP_RSVD_LO = 3'd6;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CNT_W-1:0]      cfg_wdata;

    int mismatches;
    int reports_outstanding;
    int items_seen;
    int dumps_seen;
    int reports_seen;
    int cycle_count = 0;
    int burst_left  = 0;
    int live_count  = NUM_COUNTERS;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    statistics_counter_bank u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    statistics_counter_bank_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .in_data             (in_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_data            (out_data),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .mismatches          (mismatches),
        .reports_outstanding (reports_outstanding),
        .items_seen          (items_seen),
        .dumps_seen          (dumps_seen),
        .reports_seen        (reports_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, reports_outstanding);
            $display("statistics_counter_bank regression: fail");
            $finish;
        end
    end

    function automatic in_item_t counter_op(input logic [2:0] opc, input logic [IDX_W-1:0] idx,
                                            input logic signed [VAL_W-1:0] val);
        in_item_t item;
        item.opcode        = opc;
        item.counter_index = idx;
        item.operand_value = val;
        return item;
    endfunction

    // Random op; indexes lean toward a few low counters so that values build up.
    function automatic in_item_t random_op(input int live);
        in_item_t item;
        int       pick;
        int       span;
        int       near_zero;
        pick = $urandom_range(0, 99);
        if (pick < 22)      item.opcode = OP_INC;
        else if (pick < 38) item.opcode = OP_DEC;
        else if (pick < 54) item.opcode = OP_SET;
        else if (pick < 72) item.opcode = OP_RAISE;
        else if (pick < 90) item.opcode = OP_READ;
        else if (pick < 96) item.opcode = OP_DUMP;
        else                item.opcode = $urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO;
        span = (live < 8) ? live : 8;
        case ($urandom_range(0, 9))
            0, 1:       item.counter_index = IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
            2, 3, 4, 5: item.counter_index = (span > 0)
                                             ? IDX_W'($urandom_range(0, span - 1))
                                             : IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
            default:    item.counter_index = (live > 0)
                                             ? IDX_W'($urandom_range(0, live - 1))
                                             : IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
        endcase
        near_zero = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 7))
            3, 4:    item.operand_value = VAL_W'(near_zero);
            5:       item.operand_value = VAL_MAX;
            6:       item.operand_value = VAL_MIN;
            7:       item.operand_value = $urandom_range(0, 1) ? VAL_MAX - near_zero - 8
                                                               : VAL_MIN + near_zero + 8;
            default: item.operand_value = {$urandom, $urandom};
        endcase
        return item;
    endfunction

    // Offer one item, inserting a random gap between bursts; valid stays up afterward.
    task automatic offer_item(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic offer_random(input int count);
        repeat (count)
            offer_item(random_op(live_count));
    endtask

    // Hold the sender until every report is back, then let the bank settle.
    task automatic drain_bank();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CNT_W-1:0] active, input logic verbose);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ACTIVE;
        cfg_wdata <= active;
        @(posedge clk);
        cfg_addr  <= CFG_VERBOSE;
        cfg_wdata <= CNT_W'(verbose);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        live_count = (active > NUM_COUNTERS) ? NUM_COUNTERS : int'(active);
    endtask

    // Receiver: free-running stretches, random stalls and an occasional long hold-off.
    initial
    begin : receiver
        int spell;
        spell = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            spell++;
            if (spell % 40 == 6)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                case ($urandom_range(0, 3))
                    0:
                    begin
                        out_ready <= 1'b1;
                        repeat ($urandom_range(5, 40)) @(posedge clk);
                    end
                    1:
                        repeat ($urandom_range(5, 30))
                        begin
                            out_ready <= ($urandom_range(0, 3) != 0);
                            @(posedge clk);
                        end
                    2:
                        repeat ($urandom_range(5, 30))
                        begin
                            out_ready <= 1'($urandom_range(0, 1));
                            @(posedge clk);
                        end
                    default:
                    begin
                        out_ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge clk);
                    end
                endcase
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_ACTIVE;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full bank, quiet dump: wrap, raise and reserved-op corners
        apply_setting(CNT_W'(NUM_COUNTERS), 1'b0);
        offer_item(counter_op(OP_DUMP, 6'd17, '0));
        offer_item(counter_op(OP_READ, 6'd0, VAL_MAX));
        offer_item(counter_op(OP_INC, 6'd0, '0));
        offer_item(counter_op(OP_INC, 6'd0, '1));
        offer_item(counter_op(OP_DEC, 6'd1, '0));
        offer_item(counter_op(OP_SET, 6'd2, VAL_MAX));
        offer_item(counter_op(OP_INC, 6'd2, '0));
        offer_item(counter_op(OP_READ, 6'd2, '0));
        offer_item(counter_op(OP_SET, 6'd63, VAL_MIN));
        offer_item(counter_op(OP_DEC, 6'd63, '0));
        offer_item(counter_op(OP_RAISE, 6'd4, -64'sd5));
        offer_item(counter_op(OP_RAISE, 6'd4, '0));
        offer_item(counter_op(OP_RAISE, 6'd4, 64'sd100));
        offer_item(counter_op(OP_RAISE, 6'd4, VAL_MAX));
        offer_item(counter_op(OP_RAISE, 6'd5, VAL_MIN));
        offer_item(counter_op(OP_READ, 6'd63, '0));
        offer_item(counter_op(OP_RSVD_LO, 6'd3, '1));
        offer_item(counter_op(OP_RSVD_HI, 6'd63, VAL_MIN));
        offer_item(counter_op(OP_READ, 6'd4, '0));
        offer_item(counter_op(OP_DUMP, 6'd63, '1));
        drain_bank();

        // single counter, verbose: everything above index 0 is rejected
        apply_setting(7'd1, 1'b1);
        offer_item(counter_op(OP_INC, 6'd1, '0));
        offer_item(counter_op(OP_READ, 6'd63, '0));
        offer_item(counter_op(OP_DUMP, 6'd0, '0));
        offer_random(60);
        drain_bank();

        // no counters: every index rejected, dump always empty
        apply_setting(7'd0, 1'b0);
        offer_item(counter_op(OP_INC, 6'd0, '0));
        offer_item(counter_op(OP_DUMP, 6'd0, '0));
        offer_random(30);
        drain_bank();

        // oversized count clamps to the bank size; verbose dump reports all of it
        apply_setting(7'd127, 1'b1);
        offer_item(counter_op(OP_DUMP, 6'd0, '0));
        offer_random(90);
        drain_bank();

        apply_setting(CNT_W'($urandom_range(2, NUM_COUNTERS - 1)), 1'($urandom_range(0, 1)));
        offer_random(87);
        drain_bank();

        apply_setting(CNT_W'(NUM_COUNTERS), 1'b0);
        offer_random(87);
        drain_bank();

        $display("covered %0d items (%0d dumps) and %0d reports over six register settings",
                 items_seen, dumps_seen, reports_seen);
        $display("settings included no counters, one counter, a clamped count and verbose dumps;"
                 , " %0d mismatches", mismatches);
        if (mismatches == 0 && reports_outstanding == 0)
            $display("statistics_counter_bank regression: pass");
        else
            $display("statistics_counter_bank regression: fail");
        $finish;
    end

endmodule

// ===== statistics_counter_bank.f =====
rtl/scb_pkg.sv
rtl/scb_ctrl.sv
rtl/scb_datapath.sv
rtl/statistics_counter_bank.sv
test/statistics_counter_bank_checker.sv
test/statistics_counter_bank_test.sv
